// ===== hdl/heater_pulse_energy_controller_defines.svh =====
// Assertion macros of the heater pulse energy controller, used by hpec_ctrl.
`ifndef HEATER_PULSE_ENERGY_CONTROLLER_DEFINES_SVH
`define HEATER_PULSE_ENERGY_CONTROLLER_DEFINES_SVH

// The expression holds at every clock edge out of reset.
`define HPEC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("heater controller check failed");

// The consequent holds in the same cycle as the antecedent.
`define HPEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heater controller check failed");

// The consequent holds in the cycle after the antecedent.
`define HPEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heater controller check failed");

`endif

// ===== hdl/hpec_pkg.sv =====
// Types, codes and constants of the heater pulse energy controller.
`timescale 1ns / 1ps
package hpec_pkg;

    localparam int IDX_W    = 3;
    localparam int CFG_W    = 16;
    localparam int NUM_W    = 44;
    localparam int DEN_W    = 30;
    localparam int QUOT_W   = 7;
    localparam int SAT_BITS = 7;

    localparam logic [IDX_W-1:0] REG_AUTO_ENABLE = 3'd0;
    localparam logic [IDX_W-1:0] REG_TARGET_TEMP = 3'd1;
    localparam logic [IDX_W-1:0] REG_HEATER_WATTS = 3'd2;
    localparam logic [IDX_W-1:0] REG_WATER_MASS = 3'd3;
    localparam logic [IDX_W-1:0] REG_HEAT_CAP = 3'd4;

    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_PULSE      = 3'd1;
    localparam logic [2:0] EV_SETTLE     = 3'd2;
    localparam logic [2:0] EV_WAIT_END   = 3'd3;
    localparam logic [2:0] EV_IDLE_WAIT  = 3'd4;

    localparam logic [31:0] SETTLE_MS    = 32'd30000;
    localparam logic [31:0] IDLE_WAIT_MS = 32'd10000;
    localparam logic [31:0] MS_PER_S     = 32'd1000;
    localparam logic [4:0]  MAX_PULSE_S  = 5'd20;
    localparam logic [13:0] DEN_SCALE    = 14'd16000;

    localparam logic              RST_AUTO_ENABLE = 1'b0;
    localparam logic signed [11:0] RST_TARGET_TEMP = 12'sd320;
    localparam logic [15:0]       RST_HEATER_WATTS = 16'd880;
    localparam logic [15:0]       RST_WATER_MASS  = 16'd1500;
    localparam logic [15:0]       RST_HEAT_CAP    = 16'd4184;

    typedef struct packed {
        logic               auto_enable;
        logic signed [11:0] target_temp;
        logic [15:0]        heater_watts;
        logic [15:0]        water_mass_grams;
        logic [15:0]        heat_capacity_milli;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [11:0] measured_temp;
    } in_t;

    typedef struct packed {
        logic       heater_on;
        logic [2:0] event_res;
        logic [4:0] pulse_seconds;
    } out_t;

    typedef struct packed {
        logic       done;
        logic [4:0] len;
    } eu_status_t;

    typedef enum logic [2:0] {
        EU_IDLE,
        EU_MUL1,
        EU_MUL2,
        EU_DIV,
        EU_DONE
    } eu_phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CALC,
        ST_EMIT
    } ctrl_state_t;

endpackage

// ===== hdl/hpec_cfg_regs.sv =====
// Configuration register file of the heater pulse energy controller.
`timescale 1ns / 1ps
module hpec_cfg_regs import hpec_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_AUTO_ENABLE: cfg_next.auto_enable = cfg_wdata[0];
                REG_TARGET_TEMP: cfg_next.target_temp = $signed(cfg_wdata[11:0]);
                REG_HEATER_WATTS: cfg_next.heater_watts = cfg_wdata;
                REG_WATER_MASS: cfg_next.water_mass_grams = cfg_wdata;
                REG_HEAT_CAP: cfg_next.heat_capacity_milli = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.auto_enable         <= RST_AUTO_ENABLE;
            cfg_reg.target_temp         <= RST_TARGET_TEMP;
            cfg_reg.heater_watts        <= RST_HEATER_WATTS;
            cfg_reg.water_mass_grams    <= RST_WATER_MASS;
            cfg_reg.heat_capacity_milli <= RST_HEAT_CAP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/hpec_energy_unit.sv =====
// Bit-serial multiplier and restoring divider that give the pulse length in seconds.
`timescale 1ns / 1ps
module hpec_energy_unit import hpec_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  cfg_t               cfg,
    input  logic signed [11:0] measured_temp,
    output eu_status_t         status
);

    eu_phase_t          phase_reg, phase_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [NUM_W-1:0]   acc_reg, acc_next;
    logic [NUM_W-1:0]   mcand_reg, mcand_next;
    logic [15:0]        mplr_reg, mplr_next;
    logic [11:0]        diff_reg, diff_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic [4:0]         len_reg, len_next;

    logic signed [12:0] diff_full;
    logic [DEN_W-1:0]   den;
    logic [NUM_W-1:0]   acc_sum;
    logic               rem_ge;
    logic [QUOT_W-1:0]  quot_new;

    assign diff_full = 13'(cfg.target_temp) - 13'(measured_temp);
    assign den       = DEN_W'(cfg.heater_watts) * DEN_W'(DEN_SCALE);
    assign acc_sum   = mplr_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
    assign rem_ge    = acc_reg >= mcand_reg;
    assign quot_new  = {quot_reg[QUOT_W-2:0], rem_ge};

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        diff_next  = diff_reg;
        quot_next  = quot_reg;
        len_next   = len_reg;
        unique case (phase_reg)
            EU_IDLE: begin
                if (start) begin
                    diff_next  = diff_full[11:0];
                    acc_next   = '0;
                    mcand_next = NUM_W'(cfg.water_mass_grams);
                    mplr_next  = cfg.heat_capacity_milli;
                    cnt_next   = 4'd15;
                    if (diff_full[12] || diff_full == '0) begin
                        len_next   = '0;
                        phase_next = EU_DONE;
                    end else begin
                        phase_next = EU_MUL1;
                    end
                end
            end
            EU_MUL1: begin
                acc_next   = acc_sum;
                mcand_next = {mcand_reg[NUM_W-2:0], 1'b0};
                mplr_next  = {1'b0, mplr_reg[15:1]};
                cnt_next   = cnt_reg - 4'd1;
                if (cnt_reg == '0) begin
                    acc_next   = '0;
                    mcand_next = NUM_W'(acc_sum[31:0]);
                    mplr_next  = {4'd0, diff_reg};
                    cnt_next   = 4'd11;
                    phase_next = EU_MUL2;
                end
            end
            EU_MUL2: begin
                acc_next   = acc_sum;
                mcand_next = {mcand_reg[NUM_W-2:0], 1'b0};
                mplr_next  = {1'b0, mplr_reg[15:1]};
                cnt_next   = cnt_reg - 4'd1;
                if (cnt_reg == '0) begin
                    mcand_next = {8'd0, den, 6'd0};
                    quot_next  = '0;
                    cnt_next   = 4'(QUOT_W - 1);
                    if (acc_sum == '0) begin
                        len_next   = '0;
                        phase_next = EU_DONE;
                    end else if (acc_sum[NUM_W-1:SAT_BITS] >=
                                 (NUM_W-SAT_BITS)'(den)) begin
                        len_next   = MAX_PULSE_S;
                        phase_next = EU_DONE;
                    end else begin
                        phase_next = EU_DIV;
                    end
                end
            end
            EU_DIV: begin
                if (rem_ge) begin
                    acc_next = acc_reg - mcand_reg;
                end
                quot_next  = quot_new;
                mcand_next = {1'b0, mcand_reg[NUM_W-1:1]};
                cnt_next   = cnt_reg - 4'd1;
                if (cnt_reg == '0) begin
                    len_next   = (quot_new > QUOT_W'(MAX_PULSE_S)) ? MAX_PULSE_S
                                                                  : quot_new[4:0];
                    phase_next = EU_DONE;
                end
            end
            EU_DONE: begin
                phase_next = EU_IDLE;
            end
            default: begin
                phase_next = EU_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= EU_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
        diff_reg  <= diff_next;
        quot_reg  <= quot_next;
        len_reg   <= len_next;
    end

    assign status.done = (phase_reg == EU_DONE);
    assign status.len  = len_reg;

endmodule

// ===== hdl/hpec_ctrl.sv =====
// Tick sequencer, deadline state and result register of the heater controller.
`timescale 1ns / 1ps
`include "heater_pulse_energy_controller_defines.svh"
module hpec_ctrl import hpec_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_t                s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_t               m_data,
    output logic               eu_start,
    output logic signed [11:0] eu_temp,
    input  eu_status_t         eu_status
);

    ctrl_state_t state_reg, state_next;
    in_t         in_reg, in_next;
    logic        heater_reg, heater_next;
    logic [31:0] pd_reg, pd_next;
    logic [31:0] wd_reg, wd_next;
    out_t        res_reg, res_next;
    out_t        out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic        heater_tmp;
    logic        slot_free;
    logic        load;
    logic [31:0] pulse_ms;

    assign slot_free = !out_valid_reg || m_ready;
    assign load      = (state_reg == ST_EMIT) && slot_free;
    assign pulse_ms  = 32'(eu_status.len) * MS_PER_S;
    assign eu_temp   = in_reg.measured_temp;

    always_comb begin
        state_next     = state_reg;
        in_next        = in_reg;
        heater_next    = heater_reg;
        pd_next        = pd_reg;
        wd_next        = wd_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        s_ready        = 1'b0;
        eu_start       = 1'b0;
        heater_tmp     = heater_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                res_next.event_res     = EV_NONE;
                res_next.pulse_seconds = '0;
                res_next.heater_on     = heater_reg;
                state_next             = ST_EMIT;
                if (!cfg.auto_enable) begin
                    pd_next = '0;
                    wd_next = '0;
                end else begin
                    if (in_reg.measured_temp > cfg.target_temp) begin
                        heater_tmp = 1'b0;
                    end
                    if (pd_reg != '0) begin
                        if (in_reg.now_ms > pd_reg) begin
                            heater_tmp         = 1'b0;
                            pd_next            = '0;
                            wd_next            = in_reg.now_ms + SETTLE_MS;
                            res_next.event_res = EV_SETTLE;
                        end
                    end else if (wd_reg != '0) begin
                        if (in_reg.now_ms > wd_reg) begin
                            wd_next            = '0;
                            res_next.event_res = EV_WAIT_END;
                        end
                    end else begin
                        eu_start   = 1'b1;
                        state_next = ST_CALC;
                    end
                    heater_next        = heater_tmp;
                    res_next.heater_on = heater_tmp;
                end
            end
            ST_CALC: begin
                if (eu_status.done) begin
                    if (eu_status.len != '0) begin
                        pd_next                = in_reg.now_ms + pulse_ms;
                        heater_next            = 1'b1;
                        res_next.heater_on     = 1'b1;
                        res_next.event_res     = EV_PULSE;
                        res_next.pulse_seconds = eu_status.len;
                    end else begin
                        wd_next            = in_reg.now_ms + IDLE_WAIT_MS;
                        res_next.event_res = EV_IDLE_WAIT;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            heater_reg    <= 1'b0;
            pd_reg        <= '0;
            wd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            heater_reg    <= heater_next;
            pd_reg        <= pd_next;
            wd_reg        <= wd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // A pulse and a wait are never armed together.
    `HPEC_ASSERT_ALWAYS(a_one_deadline, aclk, aresetn, !(pd_reg != '0 && wd_reg != '0))
    `HPEC_ASSERT_IMPL(a_pulse_result, aclk, aresetn, load && res_reg.event_res == EV_PULSE, res_reg.heater_on && res_reg.pulse_seconds != '0 && res_reg.pulse_seconds <= MAX_PULSE_S)
    `HPEC_ASSERT_IMPL(a_secs_only_pulse, aclk, aresetn, load && res_reg.event_res != EV_PULSE, res_reg.pulse_seconds == '0)
    `HPEC_ASSERT_NEXT(a_manual_clears, aclk, aresetn, state_reg == ST_CHECK && !cfg.auto_enable, pd_reg == '0 && wd_reg == '0)
    `HPEC_ASSERT_IMPL(a_len_capped, aclk, aresetn, eu_status.done, eu_status.len <= MAX_PULSE_S)

endmodule

// ===== hdl/heater_pulse_energy_controller.sv =====
// Heater pulse energy controller: the tick-driven timed heater pulse regulator.
//
// Use: each transaction on the s_ channel is one tick that carries the current
// time in milliseconds and a measured temperature. Every tick gives exactly one
// transaction on the m_ channel with the heater level, an event code and the
// pulse length in seconds when a pulse has just started.
// The configuration port writes one register per cycle at cfg_index when cfg_we
// is high; the user must write it only while no tick is in progress, and the
// block itself does not enforce this. A tick that needs no energy calculation
// goes from the input register through the check state to the result register;
// one that computes a pulse uses the bit-serial multiplier and, unless it ends
// early, the seven step restoring divider. One tick is processed at a time, so
// no new tick is accepted until the last one has been passed on for output.
// A finished result waits in the output register while the next tick is taken
// and computed; if the receiver still stalls, the block holds the new result and
// accepts nothing further until the output register is free.
// Reset, synchronous and active low on aresetn, turns the heater off, disarms
// both deadlines, loads the register defaults and empties the output register.
`timescale 1ns / 1ps
module heater_pulse_energy_controller import hpec_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    cfg_t               cfg;
    logic               eu_start;
    logic signed [11:0] eu_temp;
    eu_status_t         eu_status;
    in_t                unused_in;

    assign unused_in = s_data;

    hpec_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hpec_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (unused_in),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .eu_start  (eu_start),
        .eu_temp   (eu_temp),
        .eu_status (eu_status)
    );

    hpec_energy_unit u_energy_unit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (eu_start),
        .cfg           (cfg),
        .measured_temp (eu_temp),
        .status        (eu_status)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the heater pulse energy controller, predictor included.
`timescale 1ns / 1ps
module tb_top;
    import hpec_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int PHASES          = 12;
    localparam int TICKS_PER_PHASE = 118;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_t              s_data;
    logic             m_valid;
    logic             m_ready;
    out_t             m_data;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    heater_pulse_energy_controller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    class heater_tracker;
        logic               auto_on;
        logic signed [11:0] target;
        logic [15:0]        watts;
        logic [15:0]        mass;
        logic [15:0]        cap;
        logic               level;
        logic [31:0]        pulse_dl;
        logic [31:0]        wait_dl;
        out_t               pending_reports[$];
        int unsigned        errors;

        function new();
            auto_on  = RST_AUTO_ENABLE;
            target   = RST_TARGET_TEMP;
            watts    = RST_HEATER_WATTS;
            mass     = RST_WATER_MASS;
            cap      = RST_HEAT_CAP;
            level    = 1'b0;
            pulse_dl = '0;
            wait_dl  = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_AUTO_ENABLE:  auto_on = val[0];
                REG_TARGET_TEMP:  target  = val[11:0];
                REG_HEATER_WATTS: watts   = val;
                REG_WATER_MASS:   mass    = val;
                REG_HEAT_CAP:     cap     = val;
                default: ;
            endcase
        endfunction

        function logic [4:0] heat_pulse_s(logic signed [11:0] measured);
            logic signed [12:0] diff;
            logic [12:0]        mag;
            longint unsigned    energy;
            longint unsigned    scale;
            longint unsigned    quot;
            diff = target - measured;
            if (diff <= 0) return '0;
            mag = diff;
            energy = 64'(mass) * 64'(cap) * 64'(mag);
            if (energy == 0) return '0;
            scale = 64'(watts) * 64'(DEN_SCALE);
            if (scale == 0) return MAX_PULSE_S;
            quot = energy / scale;
            return (quot > 64'(MAX_PULSE_S)) ? MAX_PULSE_S : quot[4:0];
        endfunction

        function void note_tick(in_t t);
            out_t       r;
            logic [4:0] len;
            r = '0;
            if (auto_on) begin
                if (t.measured_temp > target) level = 1'b0;
                if (pulse_dl != 0) begin
                    if (t.now_ms > pulse_dl) begin
                        level       = 1'b0;
                        pulse_dl    = '0;
                        wait_dl     = t.now_ms + SETTLE_MS;
                        r.event_res = EV_SETTLE;
                    end
                end else if (wait_dl != 0) begin
                    if (t.now_ms > wait_dl) begin
                        wait_dl     = '0;
                        r.event_res = EV_WAIT_END;
                    end
                end else begin
                    len = heat_pulse_s(t.measured_temp);
                    if (len != 0) begin
                        pulse_dl        = t.now_ms + 32'(len) * MS_PER_S;
                        level           = 1'b1;
                        r.event_res     = EV_PULSE;
                        r.pulse_seconds = len;
                    end else begin
                        wait_dl     = t.now_ms + IDLE_WAIT_MS;
                        r.event_res = EV_IDLE_WAIT;
                    end
                end
            end else begin
                pulse_dl = '0;
                wait_dl  = '0;
            end
            r.heater_on = level;
            pending_reports.push_back(r);
        endfunction

        function void check_report(out_t got);
            out_t want;
            if (pending_reports.size() == 0) begin
                $display("%0t: result with none outstanding: %p", $time, got);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            if (got.heater_on !== want.heater_on) begin
                $display("%0t: heater_on expected %0d, actual %0d",
                         $time, want.heater_on, got.heater_on);
                errors++;
            end
            if (got.event_res !== want.event_res) begin
                $display("%0t: event_res expected %0d, actual %0d",
                         $time, want.event_res, got.event_res);
                errors++;
            end
            if (got.pulse_seconds !== want.pulse_seconds) begin
                $display("%0t: pulse_seconds expected %0d, actual %0d",
                         $time, want.pulse_seconds, got.pulse_seconds);
                errors++;
            end
        endfunction
    endclass

    heater_tracker board;
    int            cycles = 0;
    logic [31:0]   clock_ms;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("heater_pulse_energy_controller verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_report(m_data);
    end

    initial begin
        int mode;
        int span;
        int hold;
        m_ready <= 1'b0;
        hold = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) == 0);
                    default: begin
                        if (hold > 0) begin
                            m_ready <= 1'b0;
                            hold--;
                        end else begin
                            m_ready <= 1'b1;
                            hold = $urandom_range(0, 30);
                        end
                    end
                endcase
            end
        end
    end

    task automatic send_tick(input in_t t);
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        board.note_tick(t);
        @(negedge aclk);
    endtask

    task automatic tick_at(input logic [31:0] now, input int temp);
        in_t t;
        t.now_ms        = now;
        t.measured_temp = 12'(temp);
        send_tick(t);
    endtask

    task automatic settle_block();
        s_valid <= 1'b0;
        while (board.pending_reports.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic load_config(input logic en, input logic signed [11:0] tgt,
                               input logic [15:0] w, input logic [15:0] m,
                               input logic [15:0] c);
        write_reg(REG_AUTO_ENABLE, {15'd0, en});
        write_reg(REG_TARGET_TEMP, 16'(tgt));
        write_reg(REG_HEATER_WATTS, w);
        write_reg(REG_WATER_MASS, m);
        write_reg(REG_HEAT_CAP, c);
        write_reg(REG_HEAT_CAP + 3'($urandom_range(1, 3)), 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [11:0] any_temp();
        return 12'(int'($urandom_range(0, 2880)) - 880);
    endfunction

    function automatic in_t next_tick();
        in_t t;
        int  sel;
        int  temp;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            clock_ms += $urandom_range(0, 4000);
        end else if (sel < 82) begin
            clock_ms += $urandom_range(4000, 40000);
        end else if (sel < 94) begin
            if (board.pulse_dl != 0) clock_ms = board.pulse_dl + $urandom_range(0, 1);
            else if (board.wait_dl != 0) clock_ms = board.wait_dl + $urandom_range(0, 1);
            else clock_ms += 1000;
        end else if (sel < 97) begin
            clock_ms = $urandom;
        end else begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40000);
        end
        if ($urandom_range(0, 99) < 80) begin
            temp = int'(board.target) + 10 - int'($urandom_range(0, 70));
            if (temp < -880) temp = -880;
            if (temp > 2000) temp = 2000;
        end else begin
            temp = int'($urandom_range(0, 2880)) - 880;
        end
        t.now_ms        = clock_ms;
        t.measured_temp = 12'(temp);
        return t;
    endfunction

    task automatic run_phase();
        int burst_left;
        int gap;
        burst_left = 0;
        for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) == 0) gap = 0;
                else gap = $urandom_range(1, ($urandom_range(0, 1) != 0) ? 8 : 60);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            burst_left--;
            send_tick(next_tick());
        end
    endtask

    initial begin
        board     = new();
        clock_ms  = '0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tick_at(32'd5, 320);
        settle_block();
        write_reg(REG_AUTO_ENABLE, 16'd1);
        cfg_we <= 1'b0;
        tick_at(32'd1000, 319);
        tick_at(32'd11000, 0);
        tick_at(32'd11001, 0);
        tick_at(32'd12000, -880);
        tick_at(32'd13000, 2000);
        tick_at(32'd32001, 300);
        tick_at(32'd62002, 300);
        tick_at(32'd70000, 310);
        tick_at(32'd74001, 310);
        tick_at(32'd104002, 320);
        // Deadline sums that wrap to zero leave the deadline unarmed.
        tick_at(32'hFFFF_D8F0, 320);
        tick_at(32'hFFFF_B1E0, -880);
        tick_at(32'h1000_0000, -880);
        tick_at(32'hFFFF_8AD0, 2000);
        tick_at(32'hFFFF_8AD1, 320);
        tick_at(32'hFFFF_FFFF, 320);

        for (int p = 0; p < PHASES; p++) begin
            settle_block();
            case (p)
                0: load_config(1'b1, RST_TARGET_TEMP, RST_HEATER_WATTS, RST_WATER_MASS,
                               RST_HEAT_CAP);
                1: load_config(1'b1, -12'sd880, 16'd1, 16'hFFFF, 16'hFFFF);
                2: load_config(1'b1, 12'sd2000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: load_config(1'b0, any_temp(), 16'($urandom), 16'($urandom),
                               16'($urandom));
                4: load_config(1'b1, any_temp(), 16'd0, 16'($urandom), 16'($urandom));
                5: load_config(1'b1, any_temp(), 16'($urandom_range(1, 65535)), 16'd0,
                               16'($urandom));
                6: load_config(1'b1, any_temp(), 16'd0, 16'($urandom), 16'd0);
                default: load_config(1'b1, any_temp(), 16'($urandom_range(1, 65535)),
                                     16'($urandom), 16'($urandom));
            endcase
            run_phase();
        end

        settle_block();
        repeat (40) @(negedge aclk);
        if (board.errors == 0 && board.pending_reports.size() == 0) begin
            $display("heater_pulse_energy_controller verification clean");
        end else begin
            $display("heater_pulse_energy_controller verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/hpec_pkg.sv
hdl/hpec_cfg_regs.sv
hdl/hpec_energy_unit.sv
hdl/hpec_ctrl.sv
hdl/heater_pulse_energy_controller.sv
tb/sv/tb_top.sv
